// File: rtl/core/ulc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulc_pkg
// Shared types, widths and constants of the ultrasonic level conditioner.
// ----------------------------------------------------------------------------
package ulc_pkg;

    // fixed-point scaling of distances
    localparam int FRACTION_BITS = 8;
    localparam int MAX_ATTEMPTS  = 15;

    // field widths
    localparam int ECHO_W   = 16;
    localparam int DIST_W   = 19;
    localparam int SUM_W    = 23;
    localparam int CNT_W    = 4;
    localparam int STATUS_W = 3;
    localparam int LEVEL_W  = 8;
    localparam int CM_W     = 10;
    localparam int DZ_W     = 8;
    localparam int WGT_W    = 9;
    localparam int CFG_W    = 10;
    localparam int CFG_A_W  = 3;

    // echo time to distance: (t * 4457) >> (18 - FRACTION_BITS)
    localparam int DIST_SCALE = 4457;
    localparam int SCALE_W    = 13;
    localparam int PROD_W     = ECHO_W + SCALE_W;
    localparam int DIST_SHIFT = 18 - FRACTION_BITS;

    // low-pass filter, weights in 1/256
    localparam int WEIGHT_BITS = 8;
    localparam int WEIGHT_ONE  = 1 << WEIGHT_BITS;
    localparam int WEIGHT_HALF = 1 << (WEIGHT_BITS - 1);
    localparam int FPROD_W     = DIST_W + WGT_W;
    localparam int FSUM_W      = FPROD_W + 1;

    // level computation
    localparam int LVLC_W       = DIST_W - FRACTION_BITS;
    localparam int PERCENT_FULL = 100;
    localparam int LEVEL_NONE   = 255;
    localparam int FILT_RESET   = 50 << FRACTION_BITS;

    // shared divider
    localparam int DIV_N_W = SUM_W;
    localparam int DIV_D_W = CM_W;
    localparam int DIV_C_W = $clog2(DIV_N_W + 1);

    // burst queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_TIMEOUT  = 3'd1,
        ST_DEADZONE = 3'd2,
        ST_DRIFT    = 3'd3,
        ST_INIT     = 3'd4,
        ST_RANGE    = 3'd5
    } t_status;

    typedef enum logic [CFG_A_W-1:0] {
        CFG_DEADZONE  = 3'd0,
        CFG_MAX_DEPTH = 3'd1,
        CFG_DRIFT     = 3'd2,
        CFG_EMPTY     = 3'd3,
        CFG_FULL      = 3'd4,
        CFG_WEIGHT    = 3'd5,
        CFG_VTARGET   = 3'd6,
        CFG_ALIMIT    = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MEAN,
        S_CLASS,
        S_FMUL,
        S_FSUM,
        S_LEVEL,
        S_LDIV,
        S_EMIT
    } t_back_state;

    typedef struct packed {
        logic [DZ_W-1:0]  deadzone_cm;
        logic [CM_W-1:0]  max_depth_cm;
        logic [DZ_W-1:0]  drift_limit_cm;
        logic [CM_W-1:0]  empty_distance_cm;
        logic [CM_W-1:0]  full_distance_cm;
        logic [WGT_W-1:0] filter_weight;
        logic [CNT_W-1:0] valid_target;
        logic [CNT_W-1:0] attempt_limit;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        deadzone_cm:       8'd22,
        max_depth_cm:      10'd150,
        drift_limit_cm:    8'd10,
        empty_distance_cm: 10'd140,
        full_distance_cm:  10'd30,
        filter_weight:     9'd51,
        valid_target:      4'd5,
        attempt_limit:     4'd10
    };

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] cnt;
    } t_burst;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quotient;
    } t_div_rsp;

endpackage

// File: rtl/core/ultrasonic_level_conditioner_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_level_conditioner_top
// Echo bursts in, mean distance, status, filtered distance and fill level out.
//
//   port group   direction  handshake                  payload
//   input        in         i_in_valid / o_in_ready    i_echo_time
//   result       out        o_out_valid / i_out_ready  status, level, mean,
//                                                      filtered, valid count
//   config       in         i_cfg_we                   i_cfg_addr, i_cfg_wdata
//
// each input transaction is accepted whenever o_in_ready is high; the one that
// closes a burst queues it for the back end, which runs it through its states
// and up to two passes of the shared one-bit-per-cycle divider.
// synchronous reset restores register defaults and a 50 cm filter state.
// input stalls only while two finished bursts wait in the queue.
// ----------------------------------------------------------------------------
module ultrasonic_level_conditioner_top
    import ulc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CFG_A_W-1:0]  i_cfg_addr,
    input  logic [CFG_W-1:0]    i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [ECHO_W-1:0]   i_echo_time,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STATUS_W-1:0] o_sensor_status,
    output logic [LEVEL_W-1:0]  o_level_percent,
    output logic [DIST_W-1:0]   o_mean_distance,
    output logic [DIST_W-1:0]   o_filtered_distance,
    output logic [CNT_W-1:0]    o_valid_count
);

    t_cfg   r_cfg;
    logic   q_push, q_full, q_pop, q_empty;
    t_burst q_wdata, q_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_DEADZONE:  r_cfg.deadzone_cm       <= i_cfg_wdata[DZ_W-1:0];
                CFG_MAX_DEPTH: r_cfg.max_depth_cm      <= i_cfg_wdata[CM_W-1:0];
                CFG_DRIFT:     r_cfg.drift_limit_cm    <= i_cfg_wdata[DZ_W-1:0];
                CFG_EMPTY:     r_cfg.empty_distance_cm <= i_cfg_wdata[CM_W-1:0];
                CFG_FULL:      r_cfg.full_distance_cm  <= i_cfg_wdata[CM_W-1:0];
                CFG_WEIGHT:    r_cfg.filter_weight     <= i_cfg_wdata[WGT_W-1:0];
                CFG_VTARGET:   r_cfg.valid_target      <= i_cfg_wdata[CNT_W-1:0];
                CFG_ALIMIT:    r_cfg.attempt_limit     <= i_cfg_wdata[CNT_W-1:0];
                default:       r_cfg <= r_cfg;
            endcase
        end
    end

    ulc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_echo_time (i_echo_time),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_data    (q_wdata)
    );

    ulc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    ulc_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg               (r_cfg),
        .i_q_empty           (q_empty),
        .i_q_data            (q_rdata),
        .o_q_pop             (q_pop),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_sensor_status     (o_sensor_status),
        .o_level_percent     (o_level_percent),
        .o_mean_distance     (o_mean_distance),
        .o_filtered_distance (o_filtered_distance),
        .o_valid_count       (o_valid_count)
    );

endmodule

// File: rtl/core/ulc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulc_front
// Converts echo times to distances and accumulates bursts; a finished burst
// is pushed to the queue.
// ----------------------------------------------------------------------------
module ulc_front
    import ulc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [ECHO_W-1:0] i_echo_time,
    input  logic              i_q_full,
    output logic              o_q_push,
    output t_burst            o_q_data
);

    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [CNT_W-1:0]  r_valid, n_valid;
    logic [CNT_W-1:0]  r_att, n_att;
    logic [CNT_W-1:0]  lim;
    logic [PROD_W-1:0] prod;
    logic [DIST_W-1:0] echo_dist;
    logic              accept;
    logic              burst_end;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    assign prod      = PROD_W'(i_echo_time) * PROD_W'(DIST_SCALE);
    assign echo_dist = DIST_W'(prod >> DIST_SHIFT);
    assign lim  = (int'(i_cfg.attempt_limit) < MAX_ATTEMPTS) ?
                  i_cfg.attempt_limit : CNT_W'(MAX_ATTEMPTS);

    assign n_att     = r_att + 1'b1;
    assign n_valid   = r_valid + CNT_W'(echo_dist != '0);
    assign n_sum     = r_sum + SUM_W'(echo_dist);
    assign burst_end = !((n_valid < i_cfg.valid_target) && (n_att < lim));

    assign o_q_push     = accept && burst_end;
    assign o_q_data.sum = n_sum;
    assign o_q_data.cnt = n_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_valid <= '0;
            r_att   <= '0;
        end else if (accept) begin
            if (burst_end) begin
                r_sum   <= '0;
                r_valid <= '0;
                r_att   <= '0;
            end else begin
                r_sum   <= n_sum;
                r_valid <= n_valid;
                r_att   <= n_att;
            end
        end
    end

endmodule

// File: rtl/core/ulc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulc_queue
// Small first-in first-out queue of finished bursts between front and back.
// ----------------------------------------------------------------------------
module ulc_queue
    import ulc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_burst i_wdata,
    output logic   o_full,
    input  logic   i_pop,
    output t_burst o_rdata,
    output logic   o_empty
);

    t_burst            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: rtl/core/ulc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulc_div
// Restoring divider, one quotient bit per cycle, shared by mean and level.
// ----------------------------------------------------------------------------
module ulc_div
    import ulc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [DIV_N_W-1:0] r_num;
    logic [DIV_N_W-1:0] r_quo;
    logic [DIV_D_W-1:0] r_den;
    logic [DIV_D_W-1:0] r_rem;
    logic [DIV_C_W-1:0] r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [DIV_D_W:0]   rem_sh;
    logic [DIV_D_W:0]   rem_sub;
    logic               ge;

    assign rem_sh  = {r_rem, r_num[DIV_N_W-1]};
    assign ge      = (rem_sh >= {1'b0, r_den});
    assign rem_sub = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.dividend;
            r_den <= i_req.divisor;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_N_W-2:0], 1'b0};
            r_rem <= ge ? rem_sub[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
            r_quo <= {r_quo[DIV_N_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= DIV_C_W'(DIV_N_W);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != DIV_C_W'(1));
            r_done <= (r_cnt == DIV_C_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// File: rtl/core/ulc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulc_back
// Burst sequencer: mean, classification, low-pass filter, fill level and
// the result register.
// ----------------------------------------------------------------------------
module ulc_back
    import ulc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_q_empty,
    input  t_burst              i_q_data,
    output logic                o_q_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STATUS_W-1:0] o_sensor_status,
    output logic [LEVEL_W-1:0]  o_level_percent,
    output logic [DIST_W-1:0]   o_mean_distance,
    output logic [DIST_W-1:0]   o_filtered_distance,
    output logic [CNT_W-1:0]    o_valid_count
);

    t_back_state         r_state, n_state;
    t_status             r_status;
    t_status             cls;
    logic [CNT_W-1:0]    r_cnt;
    logic [DIST_W-1:0]   r_mean;
    logic [DIST_W-1:0]   r_filt;
    logic                r_first;
    logic [LEVEL_W-1:0]  r_level;
    logic [FPROD_W-1:0]  r_prod_a, r_prod_b;
    logic                r_out_valid;

    t_div_req            div_req;
    t_div_rsp            div_rsp;
    logic                out_load;

    logic [DIST_W-1:0]   dz, mx, dl, diff;
    logic [WGT_W-1:0]    w_eff, w_inv;
    logic [FSUM_W-1:0]   fsum;
    logic [LVLC_W-1:0]   lv_c;
    logic                lv_empty, lv_full;
    logic [CM_W-1:0]     lv_diff;
    logic [DIV_N_W-1:0]  lv_num;

    ulc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // classification
    assign dz   = DIST_W'(i_cfg.deadzone_cm) << FRACTION_BITS;
    assign mx   = DIST_W'(i_cfg.max_depth_cm) << FRACTION_BITS;
    assign dl   = DIST_W'(i_cfg.drift_limit_cm) << FRACTION_BITS;
    assign diff = (r_mean > r_filt) ? (r_mean - r_filt) : (r_filt - r_mean);

    always_comb begin
        if (r_mean == '0) begin
            cls = ST_TIMEOUT;
        end else if (r_mean <= dz) begin
            cls = ST_DEADZONE;
        end else if (r_mean > mx) begin
            cls = ST_RANGE;
        end else if ((diff > dl) && !r_first) begin
            cls = ST_DRIFT;
        end else if (r_mean < mx) begin
            cls = ST_OK;
        end else begin
            cls = ST_INIT;
        end
    end

    // filter
    assign w_eff = (i_cfg.filter_weight > WGT_W'(WEIGHT_ONE)) ?
                   WGT_W'(WEIGHT_ONE) : i_cfg.filter_weight;
    assign w_inv = WGT_W'(WEIGHT_ONE) - w_eff;
    assign fsum  = FSUM_W'(r_prod_a) + FSUM_W'(r_prod_b) + FSUM_W'(WEIGHT_HALF);

    // level
    assign lv_c     = r_filt[DIST_W-1:FRACTION_BITS];
    assign lv_empty = (lv_c >= LVLC_W'(i_cfg.empty_distance_cm));
    assign lv_full  = (lv_c <= LVLC_W'(i_cfg.full_distance_cm));
    assign lv_diff  = i_cfg.empty_distance_cm - CM_W'(lv_c);
    assign lv_num   = DIV_N_W'(lv_diff) * DIV_N_W'(PERCENT_FULL);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    n_state = (i_q_data.cnt == '0) ? S_CLASS : S_MEAN;
                end
            end
            S_MEAN: begin
                if (div_rsp.done) begin
                    n_state = S_CLASS;
                end
            end
            S_CLASS: begin
                case (cls)
                    ST_DEADZONE: n_state = S_LEVEL;
                    ST_OK:       n_state = (r_status == ST_INIT) ? S_LEVEL : S_FMUL;
                    default:     n_state = S_EMIT;
                endcase
            end
            S_FMUL:  n_state = S_FSUM;
            S_FSUM:  n_state = S_LEVEL;
            S_LEVEL: n_state = (lv_empty || lv_full) ? S_EMIT : S_LDIV;
            S_LDIV: begin
                if (div_rsp.done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_q_pop          = 1'b0;
        out_load         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = i_q_data.sum;
        div_req.divisor  = DIV_D_W'(i_q_data.cnt);
        case (r_state)
            S_IDLE: begin
                o_q_pop       = !i_q_empty;
                div_req.start = !i_q_empty && (i_q_data.cnt != '0);
            end
            S_LEVEL: begin
                div_req.start    = !(lv_empty || lv_full);
                div_req.dividend = lv_num;
                div_req.divisor  = i_cfg.empty_distance_cm - i_cfg.full_distance_cm;
            end
            S_EMIT: begin
                out_load = !r_out_valid || i_out_ready;
            end
            default: begin
                o_q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_INIT;
            r_filt   <= DIST_W'(FILT_RESET);
            r_first  <= 1'b1;
            r_level  <= LEVEL_W'(LEVEL_NONE);
        end else begin
            r_state <= n_state;
            case (r_state)
                S_CLASS: begin
                    r_status <= cls;
                    if ((cls == ST_OK) && (r_status == ST_INIT)) begin
                        r_filt  <= r_mean;
                        r_first <= 1'b0;
                    end
                end
                S_FSUM: begin
                    r_filt <= DIST_W'(fsum >> WEIGHT_BITS);
                end
                S_LEVEL: begin
                    if (lv_empty) begin
                        r_level <= '0;
                    end else if (lv_full) begin
                        r_level <= LEVEL_W'(PERCENT_FULL);
                    end
                end
                S_LDIV: begin
                    if (div_rsp.done) begin
                        r_level <= LEVEL_W'(div_rsp.quotient);
                    end
                end
                default: begin
                    r_first <= r_first;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cnt  <= i_q_data.cnt;
            r_mean <= '0;
        end else if ((r_state == S_MEAN) && div_rsp.done) begin
            r_mean <= DIST_W'(div_rsp.quotient);
        end
        if (r_state == S_FMUL) begin
            r_prod_a <= FPROD_W'(r_filt) * FPROD_W'(w_inv);
            r_prod_b <= FPROD_W'(r_mean) * FPROD_W'(w_eff);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_sensor_status     <= r_status;
            o_level_percent     <= r_level;
            o_mean_distance     <= r_mean;
            o_filtered_distance <= r_filt;
            o_valid_count       <= r_cnt;
        end
    end

    assign o_out_valid = r_out_valid;

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_level_percent <= LEVEL_W'(PERCENT_FULL)) ||
                        (o_level_percent == LEVEL_W'(LEVEL_NONE)))
        else $error("level outside 0..100 and not the no-level code");

    a_timeout_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_sensor_status == ST_TIMEOUT) == (o_valid_count == '0)))
        else $error("timeout status does not match an empty burst");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_MEAN) || (r_state == S_LDIV))
        else $error("divider finished outside a wait state");

    a_first_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_first) |-> (r_status == ST_OK) && (r_filt == r_mean))
        else $error("first run cleared without taking the mean");

endmodule
